/* rtl/mcg_pkg.sv */
package mcg_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int CELL_W  = 6;
  localparam int OP_W    = 2;

  localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd2025;
  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [CELL_W-1:0]  LAST_CELL   = 6'd41;

  // floor(x/100) = (x * 5243) >> 19 and floor(x/7) = (x * 18725) >> 17 for x < 2^14
  localparam logic [12:0] RECIP100  = 13'd5243;
  localparam int          Q100_LSB  = 19;
  localparam int          Q100_W    = 7;
  localparam int          PROD100_W = 27;
  localparam logic [14:0] RECIP7    = 15'd18725;
  localparam int          Q7_LSB    = 17;
  localparam int          Q7_W      = 11;
  localparam int          PROD7_W   = 29;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_TODAY = 2'd0,
    OP_PREV  = 2'd1,
    OP_NEXT  = 2'd2,
    OP_HOLD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_QUOT,
    PS_REM,
    PS_SUM,
    PS_MOD,
    PS_DONE
  } prep_state_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   tday;
    logic               ym_match;
  } view_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   tday;
    logic               ym_match;
    logic [2:0]         fw;
    logic [DAY_W-1:0]   dim;
    logic [DAY_W-1:0]   pdim;
  } grid_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] o;
    case (m)
      4'd2, 4'd6:   o = 3'd3;
      4'd3, 4'd11:  o = 3'd2;
      4'd4:         o = 3'd5;
      4'd7:         o = 3'd5;
      4'd8:         o = 3'd1;
      4'd9, 4'd12:  o = 3'd4;
      4'd10:        o = 3'd6;
      default:      o = 3'd0;
    endcase
    return o;
  endfunction

endpackage

/* rtl/month_calendar_grid_core.sv */
// Month view calendar grid: one navigation request in, 42 grid cells out.
// Throughput: one cell per cycle while out_stall is low; the cell sequencer
// sets the rate, date math for the next request runs under the current run.
// Reset: view is January 2025, request queue and both pipelines are empty.
module month_calendar_grid_core import mcg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [YEAR_W-1:0]  in_today_year,
  input  logic [MONTH_W-1:0] in_today_month,
  input  logic [DAY_W-1:0]   in_today_day,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [YEAR_W-1:0]  out_view_year,
  output logic [MONTH_W-1:0] out_view_month,
  output logic [CELL_W-1:0]  out_cell_index,
  output logic [DAY_W-1:0]   out_day_number,
  output logic               out_in_month,
  output logic               out_today_mark,
  output logic               out_last_cell
);

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  view_req_t q_wdata;
  view_req_t q_rdata;
  logic      grid_valid;
  logic      grid_take;
  grid_t     grid;

  mcg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_today_year  (in_today_year),
    .in_today_month (in_today_month),
    .in_today_day   (in_today_day),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  mcg_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  mcg_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .grid_valid (grid_valid),
    .grid       (grid),
    .grid_take  (grid_take)
  );

  mcg_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .grid_valid     (grid_valid),
    .grid           (grid),
    .grid_take      (grid_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_view_year  (out_view_year),
    .out_view_month (out_view_month),
    .out_cell_index (out_cell_index),
    .out_day_number (out_day_number),
    .out_in_month   (out_in_month),
    .out_today_mark (out_today_mark),
    .out_last_cell  (out_last_cell)
  );

endmodule

/* rtl/mcg_front.sv */
module mcg_front import mcg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [YEAR_W-1:0]  in_today_year,
  input  logic [MONTH_W-1:0] in_today_month,
  input  logic [DAY_W-1:0]   in_today_day,
  input  logic               q_full,
  output logic               q_push,
  output view_req_t          q_wdata
);

  logic [YEAR_W-1:0]  view_year_r, view_year_nxt;
  logic [MONTH_W-1:0] view_month_r, view_month_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    view_year_nxt  = view_year_r;
    view_month_nxt = view_month_r;
    unique case (op_t'(in_operation))
      OP_TODAY: begin
        if (in_today_year < YEAR_MIN) view_year_nxt = YEAR_MIN;
        else if (in_today_year > YEAR_MAX) view_year_nxt = YEAR_MAX;
        else view_year_nxt = in_today_year;
        if (in_today_month < MONTH_FIRST) view_month_nxt = MONTH_FIRST;
        else if (in_today_month > MONTH_LAST) view_month_nxt = MONTH_LAST;
        else view_month_nxt = in_today_month;
      end
      OP_PREV: begin
        if (view_month_r > MONTH_FIRST) begin
          view_month_nxt = view_month_r - 4'd1;
        end else if (view_year_r > YEAR_MIN) begin
          view_month_nxt = MONTH_LAST;
          view_year_nxt  = view_year_r - 14'd1;
        end
      end
      OP_NEXT: begin
        if (view_month_r < MONTH_LAST) begin
          view_month_nxt = view_month_r + 4'd1;
        end else if (view_year_r < YEAR_MAX) begin
          view_month_nxt = MONTH_FIRST;
          view_year_nxt  = view_year_r + 14'd1;
        end
      end
      OP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    q_wdata.year     = view_year_nxt;
    q_wdata.month    = view_month_nxt;
    q_wdata.tday     = in_today_day;
    q_wdata.ym_match = (view_year_nxt == in_today_year) && (view_month_nxt == in_today_month);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_year_r  <= YEAR_RESET;
      view_month_r <= MONTH_FIRST;
    end else if (q_push) begin
      view_year_r  <= view_year_nxt;
      view_month_r <= view_month_nxt;
    end
  end

endmodule

/* rtl/mcg_fifo.sv */
module mcg_fifo import mcg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  view_req_t wdata,
  input  logic      pop,
  output view_req_t rdata,
  output logic      full,
  output logic      empty
);

  view_req_t         ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("request queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("request queue read while empty");
`endif

endmodule

/* rtl/mcg_prep.sv */
module mcg_prep import mcg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  view_req_t q_rdata,
  output logic      q_pop,
  output logic      grid_valid,
  output grid_t     grid,
  input  logic      grid_take
);

  prep_state_t state_r, state_nxt;

  view_req_t              req_r;
  logic [PROD100_W-1:0]   prod_r;
  logic [Q100_W-1:0]      q100_r;
  logic                   rz_r;
  logic                   leap_r;
  logic [YEAR_W-1:0]      sum_r;
  logic [PROD7_W-1:0]     prod7_r;
  logic [DAY_W-1:0]       dim_r;
  logic [DAY_W-1:0]       pdim_r;

  logic [Q100_W-1:0]      q100;
  logic [YEAR_W-1:0]      rem100;
  logic                   early;
  logic [YEAR_W-1:0]      yy;
  logic [Q100_W-1:0]      qyy;
  logic [YEAR_W-1:0]      sum;
  logic [Q7_W-1:0]        q7;
  logic [YEAR_W-1:0]      fw_full;

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    grid_valid = 1'b0;
    unique case (state_r)
      PS_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = PS_QUOT;
        end
      end
      PS_QUOT: state_nxt = PS_REM;
      PS_REM:  state_nxt = PS_SUM;
      PS_SUM:  state_nxt = PS_MOD;
      PS_MOD:  state_nxt = PS_DONE;
      PS_DONE: begin
        grid_valid = 1'b1;
        if (grid_take) state_nxt = PS_IDLE;
      end
      default: state_nxt = PS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= PS_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    q100   = prod_r[Q100_LSB +: Q100_W];
    rem100 = req_r.year - ((YEAR_W'(q100) << 6) + (YEAR_W'(q100) << 5) + (YEAR_W'(q100) << 2));
    early  = (req_r.month < 4'd3);
    yy     = req_r.year - YEAR_W'(early);
    qyy    = q100_r - Q100_W'(early && rz_r);
    sum    = yy + (yy >> 2) - YEAR_W'(qyy) + YEAR_W'(qyy >> 2)
           + YEAR_W'(month_offset(req_r.month)) + 14'd1;
    q7      = prod7_r[Q7_LSB +: Q7_W];
    fw_full = sum_r - ((YEAR_W'(q7) << 3) - YEAR_W'(q7));
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      PS_IDLE: if (!q_empty) req_r <= q_rdata;
      PS_QUOT: prod_r <= PROD100_W'(req_r.year) * PROD100_W'(RECIP100);
      PS_REM: begin
        q100_r <= q100;
        rz_r   <= (rem100 == '0);
        leap_r <= (req_r.year[1:0] == 2'd0) && ((rem100 != '0) || (q100[1:0] == 2'd0));
      end
      PS_SUM: begin
        sum_r  <= sum;
        dim_r  <= month_len(req_r.month, leap_r);
        pdim_r <= (req_r.month == MONTH_FIRST) ? 5'd31 : month_len(req_r.month - 4'd1, leap_r);
      end
      PS_MOD: prod7_r <= PROD7_W'(sum_r) * PROD7_W'(RECIP7);
      PS_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    grid.year     = req_r.year;
    grid.month    = req_r.month;
    grid.tday     = req_r.tday;
    grid.ym_match = req_r.ym_match;
    grid.fw       = fw_full[2:0];
    grid.dim      = dim_r;
    grid.pdim     = pdim_r;
  end

`ifndef SYNTH
  a_grid_sane: assert property (@(posedge clk) disable iff (!rst_n)
    grid_valid |-> (grid.fw <= 3'd6) && (grid.dim >= 5'd28) && (grid.pdim >= 5'd28))
    else $error("month geometry out of range");
`endif

endmodule

/* rtl/mcg_emit.sv */
module mcg_emit import mcg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               grid_valid,
  input  grid_t              grid,
  output logic               grid_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [YEAR_W-1:0]  out_view_year,
  output logic [MONTH_W-1:0] out_view_month,
  output logic [CELL_W-1:0]  out_cell_index,
  output logic [DAY_W-1:0]   out_day_number,
  output logic               out_in_month,
  output logic               out_today_mark,
  output logic               out_last_cell
);

  grid_t              grid_r;
  logic               busy_r;
  logic [CELL_W-1:0]  cnt_r;
  logic               out_valid_r;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [CELL_W-1:0]  idx_r;
  logic [DAY_W-1:0]   day_r;
  logic               inm_r;
  logic               today_r;
  logic               last_r;

  logic               adv;
  logic               at_last;
  logic [6:0]         cnt7;
  logic [6:0]         fw7;
  logic [6:0]         d;
  logic [6:0]         day7;
  logic               inm;
  logic [DAY_W-1:0]   day;

  assign adv       = busy_r && (!out_valid_r || !out_stall);
  assign at_last   = (cnt_r == LAST_CELL);
  assign grid_take = grid_valid && (!busy_r || (adv && at_last));

  always_comb begin
    cnt7 = {1'b0, cnt_r};
    fw7  = 7'(grid_r.fw);
    d    = cnt7 - fw7 + 7'd1;
    if (cnt7 < fw7) begin
      day7 = 7'(grid_r.pdim) - fw7 + 7'd1 + cnt7;
      inm  = 1'b0;
    end else if (d <= 7'(grid_r.dim)) begin
      day7 = d;
      inm  = 1'b1;
    end else begin
      day7 = d - 7'(grid_r.dim);
      inm  = 1'b0;
    end
    day = day7[DAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (grid_take) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (adv) begin
        if (at_last) busy_r <= 1'b0;
        cnt_r <= cnt_r + 6'd1;
      end
      out_valid_r <= adv || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (grid_take) grid_r <= grid;
    if (adv) begin
      year_r  <= grid_r.year;
      month_r <= grid_r.month;
      idx_r   <= cnt_r;
      day_r   <= day;
      inm_r   <= inm;
      today_r <= inm && grid_r.ym_match && (day == grid_r.tday);
      last_r  <= at_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_view_year  = year_r;
  assign out_view_month = month_r;
  assign out_cell_index = idx_r;
  assign out_day_number = day_r;
  assign out_in_month   = inm_r;
  assign out_today_mark = today_r;
  assign out_last_cell  = last_r;

`ifndef SYNTH
  a_cells_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_cell)
      |=> out_valid && (out_cell_index == $past(out_cell_index) + 6'd1))
    else $error("grid run broken before last cell");
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_cell == (out_cell_index == LAST_CELL)))
    else $error("last cell mark misplaced");
  a_today_in_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_today_mark) |-> out_in_month && (out_day_number != '0))
    else $error("today flag outside viewed month");
`endif

endmodule

/* dv/tb_month_calendar_grid_core.sv */
module tb_month_calendar_grid_core import mcg_pkg::*; ();

  localparam int GRID_SIZE      = 42;
  localparam int RANDOM_ITEMS   = 408;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [CELL_W-1:0]  idx;
    logic [DAY_W-1:0]   day;
    logic               in_month;
    logic               today_mark;
    logic               last;
  } cell_t;

  class grid_scoreboard;
    int unsigned view_year;
    int unsigned view_month;
    cell_t       expected_cells[$];
    int          errors;
    int unsigned mlen[12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned moffs[12]  = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    function new();
      view_year  = 32'(YEAR_RESET);
      view_month = 32'(MONTH_FIRST);
      errors     = 0;
    endfunction

    function int unsigned month_days(int unsigned y, int unsigned m);
      int unsigned d;
      d = mlen[m - 1];
      if (m == 2 && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0)))
        d = 29;
      return d;
    endfunction

    // 0 = Sunday
    function int unsigned first_weekday(int unsigned y, int unsigned m);
      int unsigned yy;
      yy = (m < 3) ? y - 1 : y;
      return (yy + yy / 4 - yy / 100 + yy / 400 + moffs[m - 1] + 1) % 7;
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction

    function void note_request(op_t op, logic [YEAR_W-1:0] ty, logic [MONTH_W-1:0] tm,
                               logic [DAY_W-1:0] td);
      int unsigned dim;
      int unsigned fw;
      int unsigned pdim;
      int unsigned day;
      bit          inm;
      cell_t       c;
      case (op)
        OP_TODAY: begin
          view_year  = 32'((ty < YEAR_MIN) ? YEAR_MIN : ((ty > YEAR_MAX) ? YEAR_MAX : ty));
          view_month = 32'((tm < MONTH_FIRST) ? MONTH_FIRST :
                           ((tm > MONTH_LAST) ? MONTH_LAST : tm));
        end
        OP_PREV: begin
          if (view_month > 32'(MONTH_FIRST)) begin
            view_month--;
          end else if (view_year > 32'(YEAR_MIN)) begin
            view_month = 32'(MONTH_LAST);
            view_year--;
          end
        end
        OP_NEXT: begin
          if (view_month < 32'(MONTH_LAST)) begin
            view_month++;
          end else if (view_year < 32'(YEAR_MAX)) begin
            view_month = 32'(MONTH_FIRST);
            view_year++;
          end
        end
        default: ;
      endcase
      dim  = month_days(view_year, view_month);
      fw   = first_weekday(view_year, view_month);
      pdim = (view_month == 1) ? 31 : month_days(view_year, view_month - 1);
      for (int i = 0; i < GRID_SIZE; i++) begin
        if (i < fw) begin
          day = pdim - (fw - 1 - i);
          inm = 1'b0;
        end else if (i - fw + 1 <= dim) begin
          day = i - fw + 1;
          inm = 1'b1;
        end else begin
          day = i - fw + 1 - dim;
          inm = 1'b0;
        end
        c.year       = YEAR_W'(view_year);
        c.month      = MONTH_W'(view_month);
        c.idx        = CELL_W'(i);
        c.day        = DAY_W'(day);
        c.in_month   = inm;
        c.today_mark = inm && (day == 32'(td)) && (view_month == 32'(tm)) &&
                       (view_year == 32'(ty));
        c.last       = (i == GRID_SIZE - 1);
        expected_cells.push_back(c);
      end
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_cell(cell_t got);
      cell_t exp_c;
      if (expected_cells.size() == 0) begin
        $error("unexpected cell %0d with no request pending", got.idx);
        errors++;
        return;
      end
      exp_c = expected_cells.pop_front();
      compare_field("view_year", 16'(exp_c.year), 16'(got.year));
      compare_field("view_month", 16'(exp_c.month), 16'(got.month));
      compare_field("cell_index", 16'(exp_c.idx), 16'(got.idx));
      compare_field("day_number", 16'(exp_c.day), 16'(got.day));
      compare_field("in_month", 16'(exp_c.in_month), 16'(got.in_month));
      compare_field("today_mark", 16'(exp_c.today_mark), 16'(got.today_mark));
      compare_field("last_cell", 16'(exp_c.last), 16'(got.last));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_operation = '0;
  logic [YEAR_W-1:0]  in_today_year = '0;
  logic [MONTH_W-1:0] in_today_month = '0;
  logic [DAY_W-1:0]   in_today_day = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [YEAR_W-1:0]  out_view_year;
  logic [MONTH_W-1:0] out_view_month;
  logic [CELL_W-1:0]  out_cell_index;
  logic [DAY_W-1:0]   out_day_number;
  logic               out_in_month;
  logic               out_today_mark;
  logic               out_last_cell;

  grid_scoreboard sb = new();
  int             n_sent = 0;
  int             burst_left = 0;
  int             idle_cycles = 0;
  int             stall_mode = 0;
  int             stall_tick = 0;

  month_calendar_grid_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_today_year  (in_today_year),
    .in_today_month (in_today_month),
    .in_today_day   (in_today_day),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_view_year  (out_view_year),
    .out_view_month (out_view_month),
    .out_cell_index (out_cell_index),
    .out_day_number (out_day_number),
    .out_in_month   (out_in_month),
    .out_today_mark (out_today_mark),
    .out_last_cell  (out_last_cell)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver stall pattern, mode changes whenever stall_tick runs down to zero
  always @(negedge clk) begin
    if (stall_tick == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_tick <= $urandom_range(50, 300);
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    cell_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.year       = out_view_year;
      got.month      = out_view_month;
      got.idx        = out_cell_index;
      got.day        = out_day_number;
      got.in_month   = out_in_month;
      got.today_mark = out_today_mark;
      got.last       = out_last_cell;
      sb.check_cell(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(op_t op, int ty, int tm, int td);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_today_year  <= YEAR_W'(ty);
    in_today_month <= MONTH_W'(tm);
    in_today_day   <= DAY_W'(td);
    do @(posedge clk); while (in_stall);
    sb.note_request(op, YEAR_W'(ty), MONTH_W'(tm), DAY_W'(td));
    n_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  task automatic drain_grid();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic random_date(output int y, output int m, output int d);
    y = ($urandom_range(0, 3) == 0) ? $urandom_range(1900, 2100) : $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, sb.month_days(y, m));
  endtask

  initial begin
    int   y;
    int   m;
    int   d;
    int   goal;
    int   steps;
    bit   paused;
    op_t  dir;
    paused = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(OP_HOLD, 2025, 1, 1);
    send_request(OP_TODAY, 2024, 2, 29);
    send_request(OP_NEXT, 2024, 2, 29);
    send_request(OP_TODAY, 1900, 2, 28);
    send_request(OP_NEXT, 1900, 3, 1);
    send_request(OP_TODAY, 2000, 2, 29);
    send_request(OP_TODAY, 1, 1, 1);
    send_request(OP_PREV, 1, 1, 1);
    send_request(OP_NEXT, 1, 1, 1);
    send_request(OP_PREV, 1, 1, 1);
    send_request(OP_TODAY, 9999, 12, 31);
    send_request(OP_NEXT, 9999, 12, 31);
    send_request(OP_PREV, 9999, 12, 31);
    send_request(OP_NEXT, 9999, 12, 31);
    send_request(OP_TODAY, 0, 0, 0);
    send_request(OP_TODAY, 16383, 15, 31);
    send_request(OP_TODAY, 2023, 12, 31);
    send_request(OP_NEXT, 2023, 12, 31);
    send_request(OP_PREV, 2023, 12, 31);
    send_request(OP_HOLD, 2023, 12, 0);
    send_request(OP_TODAY, 2026, 8, 31);
    send_request(OP_TODAY, 10922, 10, 21);
    drain_grid();

    goal = n_sent + RANDOM_ITEMS;
    while (n_sent < goal) begin
      if (!paused && n_sent >= goal - RANDOM_ITEMS / 2) begin
        drain_grid();
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          random_date(y, m, d);
          send_request(OP_TODAY, y, m, d);
          steps = $urandom_range(1, 6);
          repeat (steps)
            send_request($urandom_range(0, 1) ? OP_NEXT : OP_PREV, y, m, d);
        end
        6, 7: begin
          case ($urandom_range(0, 3))
            0: y = 1;
            1: y = 2;
            2: y = 9998;
            default: y = 9999;
          endcase
          m = (y <= 2) ? $urandom_range(1, 2) : $urandom_range(11, 12);
          d = $urandom_range(1, sb.month_days(y, m));
          dir = (y <= 2) ? OP_PREV : OP_NEXT;
          send_request(OP_TODAY, y, m, d);
          steps = $urandom_range(1, 5);
          repeat (steps) begin
            if ($urandom_range(0, 4) == 0)
              send_request((dir == OP_PREV) ? OP_NEXT : OP_PREV, y, m, d);
            else
              send_request(dir, y, m, d);
          end
        end
        default: begin
          send_request(op_t'($urandom_range(0, 3)), $urandom_range(0, 16383),
                       $urandom_range(0, 15), $urandom_range(0, 31));
        end
      endcase
    end

    drain_grid();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/mcg_pkg.sv
rtl/mcg_front.sv
rtl/mcg_fifo.sv
rtl/mcg_prep.sv
rtl/mcg_emit.sv
rtl/month_calendar_grid_core.sv
dv/tb_month_calendar_grid_core.sv
